### src/slcb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcb_pkg
// Types, codes and constants shared by the status LED color breather.
// ----------------------------------------------------------------------------
package slcb_pkg;

  // event codes
  localparam logic [2:0] FUNC_STATUS = 3'd0;
  localparam logic [2:0] FUNC_BATT   = 3'd1;
  localparam logic [2:0] FUNC_RECOV  = 3'd2;
  localparam logic [2:0] FUNC_TICK   = 3'd3;
  localparam logic [2:0] FUNC_OFF    = 3'd4;

  // link modes
  localparam logic [1:0] MODE_OFF      = 2'd0;
  localparam logic [1:0] MODE_WIRELESS = 2'd1;
  localparam logic [1:0] MODE_WIRED    = 2'd2;

  // register indexes
  localparam logic [2:0] REG_HOST_EN    = 3'd0;
  localparam logic [2:0] REG_HOST_RED   = 3'd1;
  localparam logic [2:0] REG_HOST_GREEN = 3'd2;
  localparam logic [2:0] REG_HOST_BLUE  = 3'd3;
  localparam logic [2:0] REG_HOST_BRT   = 3'd4;
  localparam logic [2:0] REG_IDLE_BRT   = 3'd5;

  // scaling stages, applied in this order
  localparam logic [1:0] SCL_BATT   = 2'd0;
  localparam logic [1:0] SCL_HOST   = 2'd1;
  localparam logic [1:0] SCL_BREATH = 2'd2;
  localparam int unsigned NumScales = 3;

  localparam int unsigned NowW   = 40;
  localparam int unsigned DlW    = 41;
  localparam int unsigned DigitW = 4;
  localparam int unsigned NumDigits = NowW / DigitW;

  localparam logic [11:0] BreathPeriod = 12'd2400;
  localparam logic [11:0] BreathHalf   = 12'd1200;
  localparam logic [6:0]  BreathMin    = 7'd22;
  localparam logic [6:0]  LowBattScale = 7'd55;
  localparam logic [6:0]  PctFull      = 7'd100;
  localparam logic [11:0] RecoveryWindow = 12'd2500;
  localparam logic [11:0] ActiveRefresh  = 12'd1000;
  localparam logic [11:0] FastRefresh    = 12'd100;

  localparam logic [7:0] ColWlLinkB  = 8'd32;
  localparam logic [7:0] ColWlLinkG  = 8'd12;
  localparam logic [7:0] ColDim      = 8'd24;
  localparam logic [7:0] ColNumLockG = 8'd10;

  localparam logic [7:0] HostGreenReset = 8'd24;
  localparam logic [6:0] IdleBrtReset   = 7'd40;

  // ceil(2^22/100) and ceil(2^20/150): exact floors over the value ranges used
  localparam logic [15:0] PctRecip    = 16'd41944;
  localparam logic [12:0] BreathRecip = 13'd6991;

  typedef struct packed {
    logic [2:0]      func;
    logic [1:0]      mode;
    logic            link_up;
    logic            num_lock;
    logic            is_idle;
    logic            battery_low;
    logic [NowW-1:0] now_ms;
  } evt_t;

  typedef struct packed {
    logic       written;
    logic       power_on;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } res_t;

  typedef struct packed {
    logic       host_enable;
    logic [7:0] host_red;
    logic [7:0] host_green;
    logic [7:0] host_blue;
    logic [6:0] host_brightness;
    logic [6:0] idle_cap;
  } cfg_t;

  typedef struct packed {
    logic       load;
    logic       save_status;
    logic       set_batt;
    logic       set_rec;
    logic       go_off;
    logic       init;
    logic       mod_step;
    logic       br_d;
    logic       br_s;
    logic       mul;
    logic       div;
    logic [1:0] scale_sel;
    logic       finish;
    logic       push;
  } cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       ignore;
    logic       mode_zero;
    logic       batt_changed;
    logic       valid;
    logic       saved_mode_zero;
    logic       tick_due;
  } sts_t;

  // floor(p/100) for p up to 25500
  function automatic logic [7:0] pct_div(input logic [14:0] p);
    logic [30:0] prod;
    prod = {16'd0, p} * {15'd0, PctRecip};
    return prod[29:22];
  endfunction

  // floor(x/150) for x up to 8400
  function automatic logic [5:0] breath_div(input logic [13:0] x);
    logic [26:0] prod;
    prod = {13'd0, x} * {14'd0, BreathRecip};
    return prod[25:20];
  endfunction

endpackage

### src/slcb_evt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcb_evt_if
// Event channel: valid/ready handshake carrying one event beat.
// ----------------------------------------------------------------------------
interface slcb_evt_if import slcb_pkg::*; ();
  logic valid;
  logic ready;
  evt_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### src/slcb_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcb_res_if
// Result channel: valid/ready handshake carrying one strip update beat.
// ----------------------------------------------------------------------------
interface slcb_res_if import slcb_pkg::*; ();
  logic valid;
  logic ready;
  res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### src/status_led_color_breather.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// status_led_color_breather
// Event-driven status LED color engine with low-battery, brightness and
// idle breath scaling.
// ----------------------------------------------------------------------------
// Each event beat yields exactly one result beat. Events that only update
// state, are ignored or switch the strip off go from the decide state
// straight to the result; a render forms the breath phase (now mod 2400)
// one hex digit per cycle, then the breath scale (triangle distance, then
// percentage) and a multiply and a reciprocal divide for each of the three
// color scalings. One event is in flight at a time; a new event
// is taken as soon as the previous result sits in the output register,
// even if the sink has not taken it yet. Configuration writes take effect
// on the next rendered event and do not themselves produce a result.
module status_led_color_breather import slcb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  slcb_evt_if.sink    evt_i,
  slcb_res_if.source  res_o
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  slcb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  slcb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt_valid_i (evt_i.valid),
    .evt_ready_o (evt_i.ready),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  slcb_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_i         (cfg),
    .evt_payload_i (evt_i.payload),
    .sts_o         (sts),
    .res_payload_o (res_o.payload)
  );

endmodule

### src/slcb_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcb_regs
// APB register file for the host color and brightness settings.
// ----------------------------------------------------------------------------
module slcb_regs import slcb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [2:0] idx;
  logic [6:0] pct_in;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[4:2];
  // brightness writes saturate at full scale
  assign pct_in = (pwdata[6:0] > PctFull) ? PctFull : pwdata[6:0];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_HOST_EN:    cfg_d.host_enable     = pwdata[0];
        REG_HOST_RED:   cfg_d.host_red        = pwdata[7:0];
        REG_HOST_GREEN: cfg_d.host_green      = pwdata[7:0];
        REG_HOST_BLUE:  cfg_d.host_blue       = pwdata[7:0];
        REG_HOST_BRT:   cfg_d.host_brightness = pct_in;
        REG_IDLE_BRT:   cfg_d.idle_cap        = pct_in;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.host_enable     <= 1'b0;
      cfg_q.host_red        <= 8'd0;
      cfg_q.host_green      <= HostGreenReset;
      cfg_q.host_blue       <= 8'd0;
      cfg_q.host_brightness <= PctFull;
      cfg_q.idle_cap        <= IdleBrtReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    prdata = 32'd0;
    case (idx)
      REG_HOST_EN:    prdata = {31'd0, cfg_q.host_enable};
      REG_HOST_RED:   prdata = {24'd0, cfg_q.host_red};
      REG_HOST_GREEN: prdata = {24'd0, cfg_q.host_green};
      REG_HOST_BLUE:  prdata = {24'd0, cfg_q.host_blue};
      REG_HOST_BRT:   prdata = {25'd0, cfg_q.host_brightness};
      REG_IDLE_BRT:   prdata = {25'd0, cfg_q.idle_cap};
      default:        prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### src/slcb_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcb_dp
// Datapath: saved status, deadlines, breath phase, color scaling lanes and
// the result register.
// ----------------------------------------------------------------------------
module slcb_dp import slcb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  cfg_t cfg_i,
  input  evt_t evt_payload_i,
  output sts_t sts_o,
  output res_t res_payload_o
);

  // saved status and deadlines
  logic [1:0]     saved_mode_q, saved_mode_d;
  logic           saved_link_q, saved_link_d;
  logic           saved_num_q, saved_num_d;
  logic           saved_idle_q, saved_idle_d;
  logic           low_batt_q, low_batt_d;
  logic           valid_q, valid_d;
  logic           power_q, power_d;
  logic [DlW-1:0] refresh_q, refresh_d;
  logic [DlW-1:0] recovery_q, recovery_d;

  // working registers
  evt_t            item_q;
  logic [DlW-1:0]  now_ext;
  logic            written_q;
  logic [2:0][7:0] col_q;
  logic [2:0][14:0] prod_q;
  logic [11:0]     rem_q;
  logic [NowW-1:0] mod_sh_q;
  logic [10:0]     ramp_q;
  logic [6:0]      breath_q;
  res_t            res_q;

  logic [2:0][7:0] base_col;
  logic [15:0]     mod_x;
  logic [11:0]     rem_next;
  logic [10:0]     ramp_next;
  logic [13:0]     breath_x;
  logic [6:0]      brt_eff;
  logic [6:0]      scale;
  logic            fast_refresh;

  assign now_ext = {1'b0, item_q.now_ms};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= evt_payload_i;
    end
  end

  // event qualifiers for the controller
  always_comb begin
    sts_o.func   = item_q.func;
    sts_o.ignore = valid_q && (item_q.mode == saved_mode_q) &&
                   (item_q.link_up == saved_link_q) &&
                   (item_q.num_lock == saved_num_q) &&
                   (item_q.is_idle == saved_idle_q) && !item_q.is_idle;
    sts_o.mode_zero       = (item_q.mode == MODE_OFF);
    sts_o.batt_changed    = (low_batt_q != item_q.battery_low);
    sts_o.valid           = valid_q;
    sts_o.saved_mode_zero = (saved_mode_q == MODE_OFF);
    sts_o.tick_due        = (now_ext >= refresh_q);
  end

  assign fast_refresh = saved_idle_q || (now_ext < recovery_q);

  always_comb begin
    saved_mode_d = saved_mode_q;
    saved_link_d = saved_link_q;
    saved_num_d  = saved_num_q;
    saved_idle_d = saved_idle_q;
    low_batt_d   = low_batt_q;
    valid_d      = valid_q;
    power_d      = power_q;
    refresh_d    = refresh_q;
    recovery_d   = recovery_q;
    if (cmd_i.save_status) begin
      saved_mode_d = item_q.mode;
      saved_link_d = item_q.link_up;
      saved_num_d  = item_q.num_lock;
      saved_idle_d = item_q.is_idle;
      valid_d      = 1'b1;
    end
    if (cmd_i.set_batt) begin
      low_batt_d = item_q.battery_low;
    end
    if (cmd_i.set_rec) begin
      recovery_d = now_ext + DlW'(RecoveryWindow);
    end
    if (cmd_i.finish) begin
      power_d   = 1'b1;
      refresh_d = now_ext + (fast_refresh ? DlW'(FastRefresh) : DlW'(ActiveRefresh));
    end
    // off wins over a status save in the same cycle
    if (cmd_i.go_off) begin
      valid_d      = 1'b0;
      saved_idle_d = 1'b0;
      refresh_d    = '0;
      recovery_d   = '0;
      power_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      saved_mode_q <= MODE_OFF;
      saved_link_q <= 1'b0;
      saved_num_q  <= 1'b0;
      saved_idle_q <= 1'b0;
      low_batt_q   <= 1'b0;
      valid_q      <= 1'b0;
      power_q      <= 1'b0;
      refresh_q    <= '0;
      recovery_q   <= '0;
    end else begin
      saved_mode_q <= saved_mode_d;
      saved_link_q <= saved_link_d;
      saved_num_q  <= saved_num_d;
      saved_idle_q <= saved_idle_d;
      low_batt_q   <= low_batt_d;
      valid_q      <= valid_d;
      power_q      <= power_d;
      refresh_q    <= refresh_d;
      recovery_q   <= recovery_d;
    end
  end

  // status color, lane 2 red, lane 1 green, lane 0 blue
  always_comb begin
    base_col = '0;
    case (saved_mode_q)
      MODE_WIRELESS: begin
        base_col[0] = saved_link_q ? ColWlLinkB : ColDim;
        base_col[1] = saved_link_q ? ColWlLinkG : 8'd0;
      end
      MODE_WIRED: begin
        if (saved_link_q) begin
          base_col[1] = ColDim;
        end else begin
          base_col[2] = ColDim;
        end
      end
      default: ;
    endcase
    if (!saved_num_q) begin
      base_col[2] = ColDim;
      base_col[1] = ColNumLockG;
      base_col[0] = 8'd0;
    end
    if (cfg_i.host_enable) begin
      base_col[2] = cfg_i.host_red;
      base_col[1] = cfg_i.host_green;
      base_col[0] = cfg_i.host_blue;
    end
  end

  // one base-16 digit of now mod 2400 per step, most significant first
  always_comb begin
    mod_x    = {rem_q, 4'b0000} + {12'd0, mod_sh_q[NowW-1 -: DigitW]};
    rem_next = mod_x[11:0];
    for (int m = 1; m < 16; m++) begin
      if (mod_x >= 16'(m * 2400)) begin
        rem_next = 12'(mod_x - 16'(m * 2400));
      end
    end
  end

  // triangle distance from the start of the period
  assign ramp_next = (rem_q < BreathHalf) ? rem_q[10:0] : 11'(BreathPeriod - rem_q);
  assign breath_x  = {ramp_q, 3'b000} - {3'b000, ramp_q};

  assign brt_eff = (saved_idle_q && (cfg_i.idle_cap < cfg_i.host_brightness)) ?
                   cfg_i.idle_cap : cfg_i.host_brightness;

  always_comb begin
    case (cmd_i.scale_sel)
      SCL_BATT:   scale = low_batt_q ? LowBattScale : PctFull;
      SCL_HOST:   scale = cfg_i.host_enable ? brt_eff : PctFull;
      SCL_BREATH: scale = saved_idle_q ? breath_q : PctFull;
      default:    scale = PctFull;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      written_q <= 1'b0;
      col_q     <= '0;
    end
    if (cmd_i.go_off) begin
      written_q <= 1'b1;
      col_q     <= '0;
    end
    if (cmd_i.init) begin
      col_q    <= base_col;
      rem_q    <= '0;
      mod_sh_q <= item_q.now_ms;
    end
    if (cmd_i.mod_step) begin
      rem_q    <= rem_next;
      mod_sh_q <= {mod_sh_q[NowW-DigitW-1:0], {DigitW{1'b0}}};
    end
    if (cmd_i.br_d) begin
      ramp_q <= ramp_next;
    end
    if (cmd_i.br_s) begin
      breath_q <= BreathMin + {1'b0, breath_div(breath_x)};
    end
    for (int c = 0; c < 3; c++) begin
      if (cmd_i.mul) begin
        prod_q[c] <= {7'd0, col_q[c]} * {8'd0, scale};
      end
      if (cmd_i.div) begin
        col_q[c] <= pct_div(prod_q[c]);
      end
    end
    if (cmd_i.finish) begin
      written_q <= 1'b1;
    end
    if (cmd_i.push) begin
      res_q.written  <= written_q;
      res_q.power_on <= power_q;
      res_q.red      <= col_q[2];
      res_q.green    <= col_q[1];
      res_q.blue     <= col_q[0];
    end
  end

  assign res_payload_o = res_q;

endmodule

### src/slcb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcb_ctrl
// Controller: decodes each event and sequences the render steps and the
// result handshake.
// ----------------------------------------------------------------------------
module slcb_ctrl import slcb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic evt_valid_i,
  output logic evt_ready_o,
  output logic res_valid_o,
  input  logic res_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_INIT   = 4'd2;
  localparam logic [3:0] S_MOD    = 4'd3;
  localparam logic [3:0] S_BRD    = 4'd4;
  localparam logic [3:0] S_BRS    = 4'd5;
  localparam logic [3:0] S_MUL    = 4'd6;
  localparam logic [3:0] S_DIV    = 4'd7;
  localparam logic [3:0] S_END    = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0] state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;
  logic       render_req;
  logic       do_off;
  logic       do_render;

  assign evt_ready_o = (state_q == S_IDLE);
  assign res_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !res_ready_i;
    cmd_o       = '0;
    render_req  = 1'b0;
    do_off      = 1'b0;
    do_render   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (evt_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        case (sts_i.func)
          FUNC_STATUS: begin
            if (!sts_i.ignore) begin
              cmd_o.save_status = 1'b1;
              do_off    = sts_i.mode_zero;
              do_render = !sts_i.mode_zero;
            end
          end
          FUNC_BATT: begin
            if (sts_i.batt_changed) begin
              cmd_o.set_batt = 1'b1;
              render_req     = 1'b1;
            end
          end
          FUNC_RECOV: begin
            cmd_o.set_rec = 1'b1;
            render_req    = 1'b1;
          end
          FUNC_TICK: render_req = sts_i.valid && sts_i.tick_due;
          FUNC_OFF:  do_off = 1'b1;
          default: ;
        endcase
        // a render with no valid status does nothing, a saved off mode turns off
        if (render_req && sts_i.valid) begin
          do_off    = sts_i.saved_mode_zero;
          do_render = !sts_i.saved_mode_zero;
        end
        cmd_o.go_off = do_off;
        state_d      = do_render ? S_INIT : S_DONE;
      end
      S_INIT: begin
        cmd_o.init = 1'b1;
        cnt_d      = '0;
        state_d    = S_MOD;
      end
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (cnt_q == 4'(NumDigits - 1)) begin
          cnt_d   = '0;
          state_d = S_BRD;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      S_BRD: begin
        cmd_o.br_d = 1'b1;
        state_d    = S_BRS;
      end
      S_BRS: begin
        cmd_o.br_s = 1'b1;
        state_d    = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul       = 1'b1;
        cmd_o.scale_sel = cnt_q[1:0];
        state_d         = S_DIV;
      end
      S_DIV: begin
        cmd_o.div = 1'b1;
        if (cnt_q == 4'(NumScales - 1)) begin
          cnt_d   = '0;
          state_d = S_END;
        end else begin
          cnt_d   = cnt_q + 4'd1;
          state_d = S_MUL;
        end
      end
      S_END: begin
        cmd_o.finish = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        // wait for the result register to free up
        if (!out_valid_q || res_ready_i) begin
          cmd_o.push  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### src/slcb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcb_checker
// Port-level checks on the status LED color breather.
// ----------------------------------------------------------------------------
module slcb_checker import slcb_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic evt_valid_i,
  input logic evt_ready_i,
  input logic res_valid_i,
  input logic res_ready_i,
  input res_t res_payload_i
);

  // a stalled result beat stays up
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result beat dropped while stalled");

  a_res_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(res_payload_i))
    else $error("result payload changed while stalled");

  // no color without a strip write
  a_quiet_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_payload_i.written |->
      res_payload_i.red == 8'd0 && res_payload_i.green == 8'd0 &&
      res_payload_i.blue == 8'd0)
    else $error("color shown on an event that did not write the strip");

  // a write with power off is the off path, always black
  a_off_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_payload_i.written && !res_payload_i.power_on |->
      res_payload_i.red == 8'd0 && res_payload_i.green == 8'd0 &&
      res_payload_i.blue == 8'd0)
    else $error("non-black write with power off");

  // one event at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_i && evt_ready_i |=> !evt_ready_i)
    else $error("event taken while the previous one is in flight");

endmodule

bind status_led_color_breather slcb_checker u_slcb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .evt_valid_i   (evt_i.valid),
  .evt_ready_i   (evt_i.ready),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .res_payload_i (res_o.payload)
);

### sim/status_led_color_breather_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// status_led_color_breather_test
// Self-checking bench for the status LED color breather. Events go in on the
// event channel with random gaps, strip updates come back with random back
// pressure, and every update beat is compared field by field with a model of
// the color, scaling, power and refresh scheduling rules. The host registers
// are rewritten over APB between phases, with the extremes among the settings.
// ----------------------------------------------------------------------------
import slcb_pkg::*;

class led_strip_tracker;
  localparam int unsigned BreathTop = 78;

  cfg_t           cfg;
  logic [1:0]     saved_mode;
  logic           saved_link;
  logic           saved_num;
  logic           saved_idle;
  logic           batt_flag;
  logic           status_ok;
  logic           power;
  logic [DlW-1:0] refresh_at;
  logic [DlW-1:0] recovery_until;
  res_t           upd;
  res_t           updates_due[$];
  int unsigned    mismatches;
  int unsigned    updates_checked;

  function new();
    cfg = '0;
    cfg.host_green = HostGreenReset;
    cfg.host_brightness = PctFull;
    cfg.idle_cap = IdleBrtReset;
    saved_mode = MODE_OFF;
    {saved_link, saved_num, saved_idle, batt_flag, status_ok, power} = '0;
    refresh_at = '0;
    recovery_until = '0;
    upd = '0;
    mismatches = 0;
    updates_checked = 0;
  endfunction

  function logic [6:0] pct_limit(logic [6:0] v);
    return (v > PctFull) ? PctFull : v;
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] val);
    case (idx)
      REG_HOST_EN:    cfg.host_enable = val[0];
      REG_HOST_RED:   cfg.host_red = val[7:0];
      REG_HOST_GREEN: cfg.host_green = val[7:0];
      REG_HOST_BLUE:  cfg.host_blue = val[7:0];
      REG_HOST_BRT:   cfg.host_brightness = pct_limit(val[6:0]);
      REG_IDLE_BRT:   cfg.idle_cap = pct_limit(val[6:0]);
      default: ;
    endcase
  endfunction

  function logic [7:0] pct_of(logic [7:0] v, int unsigned s);
    int unsigned prod;
    prod = v * s;
    return 8'(prod / PctFull);
  endfunction

  // triangle from 22 at phase 0 up to 78 at half period and back
  function int unsigned breath_pct(logic [NowW-1:0] now);
    int unsigned phase;
    int unsigned ramp;
    phase = 32'(now % NowW'(BreathPeriod));
    ramp = (phase < BreathHalf) ? phase : BreathPeriod - phase;
    return BreathMin + ramp * (BreathTop - BreathMin) / BreathHalf;
  endfunction

  function void go_dark();
    status_ok = 1'b0;
    saved_idle = 1'b0;
    refresh_at = '0;
    recovery_until = '0;
    power = 1'b0;
    upd.written = 1'b1;
    upd.red = '0;
    upd.green = '0;
    upd.blue = '0;
  endfunction

  function void render(logic [NowW-1:0] now);
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    int unsigned br;
    int unsigned bs;
    if (!status_ok) return;
    if (saved_mode == MODE_OFF) begin
      go_dark();
      return;
    end
    r = '0;
    g = '0;
    b = '0;
    if (saved_mode == MODE_WIRELESS) begin
      b = saved_link ? ColWlLinkB : ColDim;
      g = saved_link ? ColWlLinkG : 8'd0;
    end else if (saved_mode == MODE_WIRED) begin
      if (saved_link) g = ColDim;
      else r = ColDim;
    end
    if (!saved_num) begin
      r = ColDim;
      g = ColNumLockG;
      b = '0;
    end
    if (cfg.host_enable) begin
      r = cfg.host_red;
      g = cfg.host_green;
      b = cfg.host_blue;
    end
    if (batt_flag) begin
      r = pct_of(r, LowBattScale);
      g = pct_of(g, LowBattScale);
      b = pct_of(b, LowBattScale);
    end
    if (cfg.host_enable) begin
      br = cfg.host_brightness;
      if (saved_idle && cfg.idle_cap < br) br = cfg.idle_cap;
      r = pct_of(r, br);
      g = pct_of(g, br);
      b = pct_of(b, br);
    end
    if (saved_idle) begin
      bs = breath_pct(now);
      r = pct_of(r, bs);
      g = pct_of(g, bs);
      b = pct_of(b, bs);
    end
    power = 1'b1;
    upd.written = 1'b1;
    upd.red = r;
    upd.green = g;
    upd.blue = b;
    if (saved_idle || {1'b0, now} < recovery_until) refresh_at = {1'b0, now} + DlW'(FastRefresh);
    else refresh_at = {1'b0, now} + DlW'(ActiveRefresh);
  endfunction

  function void note_event(evt_t e);
    upd = '0;
    case (e.func)
      FUNC_STATUS: begin
        // unchanged non-idle status is dropped
        if (!(status_ok && e.mode == saved_mode && e.link_up == saved_link &&
              e.num_lock == saved_num && e.is_idle == saved_idle && !e.is_idle)) begin
          saved_mode = e.mode;
          saved_link = e.link_up;
          saved_num = e.num_lock;
          saved_idle = e.is_idle;
          status_ok = 1'b1;
          if (e.mode == MODE_OFF) go_dark();
          else render(e.now_ms);
        end
      end
      FUNC_BATT: begin
        if (batt_flag != e.battery_low) begin
          batt_flag = e.battery_low;
          render(e.now_ms);
        end
      end
      FUNC_RECOV: begin
        recovery_until = {1'b0, e.now_ms} + DlW'(RecoveryWindow);
        render(e.now_ms);
      end
      FUNC_TICK: begin
        if (status_ok && {1'b0, e.now_ms} >= refresh_at) render(e.now_ms);
      end
      FUNC_OFF: go_dark();
      default: ;
    endcase
    upd.power_on = power;
    updates_due.push_back(upd);
  endfunction

  function void field_check(string fname, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      mismatches++;
    end
  endfunction

  function void check_update(res_t got);
    res_t want;
    if (updates_due.size() == 0) begin
      $error("update beat with no event outstanding: %p", got);
      mismatches++;
      return;
    end
    want = updates_due.pop_front();
    updates_checked++;
    field_check("written", 8'(want.written), 8'(got.written));
    field_check("power_on", 8'(want.power_on), 8'(got.power_on));
    field_check("red", want.red, got.red);
    field_check("green", want.green, got.green);
    field_check("blue", want.blue, got.blue);
  endfunction

  function int unsigned outstanding();
    return updates_due.size();
  endfunction
endclass

module status_led_color_breather_test;
  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned NumPhases = 8;
  localparam int unsigned PhaseItems = 154;
  localparam logic [NowW-1:0] MaxNow = 40'hFF_FFFF_EFFF;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  slcb_evt_if evt ();
  slcb_res_if res ();

  status_led_color_breather uut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .evt_i   (evt),
    .res_o   (res)
  );

  led_strip_tracker strip = new();

  int unsigned     cycles = 0;
  int unsigned     events_in = 0;
  int unsigned     settings_used = 0;
  bit              gaps_on = 1'b1;
  bit              stalls_on = 1'b1;
  logic [NowW-1:0] clock_ms = '0;
  evt_t            last_status = '0;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // beat monitor: events are noted before updates of the same edge are checked
  always @(posedge clk) begin
    if (rst_n) begin
      if (evt.valid && evt.ready) begin
        strip.note_event(evt.payload);
        events_in++;
      end
      if (res.valid && res.ready) strip.check_update(res.payload);
    end
  end

  // update sink with bursts of back pressure
  initial begin
    int unsigned hold;
    res.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stalls_on && $urandom_range(0, 3) == 0) begin
        hold = $urandom_range(1, 4);
        res.ready = 1'b0;
        repeat (hold) @(negedge clk);
      end
      res.ready = 1'b1;
    end
  end

  function automatic evt_t make_event(logic [2:0] func, logic [1:0] mode, logic link,
                                      logic num, logic idle, logic batt,
                                      logic [NowW-1:0] now);
    evt_t e;
    e.func = func;
    e.mode = mode;
    e.link_up = link;
    e.num_lock = num;
    e.is_idle = idle;
    e.battery_low = batt;
    e.now_ms = now;
    return e;
  endfunction

  function automatic evt_t random_event();
    evt_t            e;
    int unsigned     pick;
    int unsigned     step;
    longint unsigned t;
    pick = $urandom_range(0, 99);
    step = $urandom_range(0, 99);
    // mostly forward time in small steps, now and then a jump anywhere
    if (step < 70) clock_ms += NowW'($urandom_range(0, 300));
    else if (step < 90) clock_ms += NowW'($urandom_range(300, 1300));
    else if (step < 95) begin
      if (clock_ms > 5000) clock_ms -= NowW'($urandom_range(0, 3000));
    end else begin
      t = (64'($urandom_range(0, 255)) << 32) | 64'($urandom);
      clock_ms = NowW'(t % (64'(MaxNow) + 1));
    end
    if (clock_ms > MaxNow) clock_ms = NowW'($urandom_range(0, 100000));
    e.now_ms = clock_ms;
    e.battery_low = 1'($urandom_range(0, 1));
    e.mode = 2'($urandom_range(0, 3));
    e.link_up = 1'($urandom_range(0, 1));
    e.num_lock = ($urandom_range(0, 4) != 0);
    e.is_idle = ($urandom_range(0, 9) < 3);
    if (pick < 28) begin
      e.func = FUNC_STATUS;
      if ($urandom_range(0, 2) == 0) begin
        // repeat the last status to hit the unchanged case
        e.mode = last_status.mode;
        e.link_up = last_status.link_up;
        e.num_lock = last_status.num_lock;
        e.is_idle = 1'b0;
      end else if ($urandom_range(0, 9) < 8) begin
        e.mode = $urandom_range(0, 1) ? MODE_WIRED : MODE_WIRELESS;
      end
      last_status = e;
    end else if (pick < 40) e.func = FUNC_BATT;
    else if (pick < 48) e.func = FUNC_RECOV;
    else if (pick < 88) e.func = FUNC_TICK;
    else if (pick < 93) e.func = FUNC_OFF;
    else e.func = 3'(FUNC_OFF + $urandom_range(1, 3));
    return e;
  endfunction

  task automatic send_event(evt_t e);
    int unsigned hold;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      hold = $urandom_range(1, 4);
      evt.valid = 1'b0;
      repeat (hold) @(negedge clk);
    end
    evt.valid = 1'b1;
    evt.payload = e;
    @(posedge clk);
    while (!evt.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    evt.valid = 1'b0;
    while (strip.outstanding() != 0) @(negedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    strip.write_reg(idx, val);
  endtask

  task automatic apply_setting(int unsigned p);
    logic [31:0] v [6];
    case (p)
      0: v = '{32'd0, 32'd0, 32'd24, 32'd0, 32'd100, 32'd40};
      1: v = '{32'd1, 32'd255, 32'd255, 32'd255, 32'd100, 32'd0};
      // out of range percentages are clamped
      2: v = '{32'd1, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd101};
      3: v = '{32'd1, 32'd255, 32'd0, 32'd128, 32'd0, 32'd100};
      4: v = '{32'd0, $urandom, $urandom, $urandom, $urandom, $urandom};
      default: v = '{$urandom_range(0, 1), $urandom, $urandom, $urandom,
                     $urandom_range(0, 127), $urandom_range(0, 127)};
    endcase
    reg_write(REG_HOST_EN, v[0]);
    reg_write(REG_HOST_RED, v[1]);
    reg_write(REG_HOST_GREEN, v[2]);
    reg_write(REG_HOST_BLUE, v[3]);
    reg_write(REG_HOST_BRT, v[4]);
    reg_write(REG_IDLE_BRT, v[5]);
    settings_used++;
  endtask

  task automatic run_directed();
    send_event(make_event(FUNC_TICK, MODE_OFF, 0, 0, 0, 0, 0));
    send_event(make_event(FUNC_BATT, MODE_OFF, 0, 0, 0, 1, 10));
    send_event(make_event(FUNC_RECOV, MODE_OFF, 0, 0, 0, 0, 1000));
    send_event(make_event(FUNC_STATUS, MODE_WIRELESS, 1, 1, 0, 0, 1000));
    send_event(make_event(FUNC_STATUS, MODE_WIRELESS, 1, 1, 0, 0, 1050));
    send_event(make_event(FUNC_TICK, MODE_OFF, 0, 0, 0, 0, 1099));
    send_event(make_event(FUNC_TICK, MODE_OFF, 0, 0, 0, 0, 1100));
    send_event(make_event(FUNC_BATT, MODE_OFF, 0, 0, 0, 1, 1200));
    send_event(make_event(FUNC_BATT, MODE_OFF, 0, 0, 0, 0, 1300));
    send_event(make_event(FUNC_STATUS, MODE_WIRED, 0, 1, 0, 0, 1400));
    send_event(make_event(FUNC_STATUS, MODE_WIRED, 1, 1, 0, 0, 1500));
    send_event(make_event(FUNC_STATUS, MODE_WIRELESS, 0, 1, 0, 0, 1600));
    send_event(make_event(FUNC_STATUS, MODE_WIRELESS, 1, 0, 0, 0, 1700));
    send_event(make_event(FUNC_STATUS, 2'd3, 1, 1, 0, 0, 4000));
    // idle breath at its low point, its peak and on the way down
    send_event(make_event(FUNC_STATUS, MODE_WIRED, 1, 1, 1, 0, 4800));
    send_event(make_event(FUNC_STATUS, MODE_WIRED, 1, 1, 1, 0, 6000));
    send_event(make_event(FUNC_TICK, MODE_OFF, 0, 0, 0, 0, 6100));
    send_event(make_event(FUNC_STATUS, MODE_WIRED, 1, 1, 1, 1, MaxNow));
    send_event(make_event(FUNC_STATUS, MODE_OFF, 1, 1, 0, 0, MaxNow));
    send_event(make_event(FUNC_TICK, MODE_OFF, 0, 0, 0, 0, MaxNow));
    for (int k = 1; k <= 3; k++)
      send_event(make_event(3'(FUNC_OFF + k), 2'd3, 1, 1, 1, 1, MaxNow));
    send_event(make_event(FUNC_STATUS, MODE_WIRELESS, 1, 1, 0, 0, 10));
    send_event(make_event(FUNC_RECOV, MODE_OFF, 0, 0, 0, 0, 20));
    send_event(make_event(FUNC_OFF, MODE_OFF, 0, 0, 0, 0, 30));
  endtask

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    evt.valid = 1'b0;
    evt.payload = '0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    run_directed();
    wait_drained();

    for (int unsigned p = 0; p < NumPhases; p++) begin
      apply_setting(p);
      for (int unsigned i = 0; i < PhaseItems; i++) begin
        // last phase and every third stretch run without idling
        gaps_on = (p != NumPhases - 1) && ((i / 40) % 3 != 2);
        stalls_on = gaps_on;
        if ($urandom_range(0, 99) == 0) wait_drained();
        send_event(random_event());
      end
      wait_drained();
    end

    repeat (30) @(negedge clk);
    $display("tb: %0d events sent, %0d strip updates checked", events_in,
             strip.updates_checked);
    $display("tb: %0d register settings, all event kinds, idle breath and clamping",
             settings_used);
    if (strip.mismatches == 0 && strip.outstanding() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
